@@ rtl/vn_pkg.sv @@
// Package for the 3D vector normalize core: widths, pipeline depths and beat types.
package vn_pkg;

  localparam int COMP_WIDTH     = 16;
  localparam int UNIT_FRAC_BITS = 14;
  localparam int UNIT_WIDTH     = UNIT_FRAC_BITS + 2;
  localparam int LANES          = 3;

  localparam int SUM_WIDTH      = 2 * COMP_WIDTH;
  localparam int REM_WIDTH      = COMP_WIDTH + 3;
  localparam int SQRT_STEPS     = COMP_WIDTH;
  localparam int SQRT_PER_STAGE = 2;
  localparam int SQRT_STAGES    = (SQRT_STEPS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;

  localparam int DREM_WIDTH     = COMP_WIDTH + 1;
  localparam int QUO_WIDTH      = UNIT_FRAC_BITS + 1;
  localparam int DIV_STEPS      = QUO_WIDTH;
  localparam int DIV_PER_STAGE  = 2;
  localparam int DIV_STAGES     = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

  localparam int FRONT_STAGES   = 3;
  localparam int LATENCY        = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + 1;

  localparam logic [QUO_WIDTH-1:0]  UNIT_ONE   = QUO_WIDTH'(1) << UNIT_FRAC_BITS;
  localparam logic [UNIT_WIDTH-1:0] UNIT_ONE_W = UNIT_WIDTH'(1) << UNIT_FRAC_BITS;

  typedef logic [COMP_WIDTH-1:0] mag_t;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] vec_x;
    logic signed [COMP_WIDTH-1:0] vec_y;
    logic signed [COMP_WIDTH-1:0] vec_z;
  } vn_in_t;

  typedef struct packed {
    logic        [COMP_WIDTH-1:0] length;
    logic signed [UNIT_WIDTH-1:0] unit_x;
    logic signed [UNIT_WIDTH-1:0] unit_y;
    logic signed [UNIT_WIDTH-1:0] unit_z;
    logic                         zero_vector;
  } vn_out_t;

  typedef struct packed {
    logic [LANES-1:0]       neg;
    mag_t [LANES-1:0]       mag;
    logic                   zero;
  } vn_meta_t;

  typedef struct packed {
    logic [COMP_WIDTH-1:0]             len;
    logic [LANES-1:0]                  neg;
    logic                              zero;
    logic [LANES-1:0][QUO_WIDTH-1:0]   quo;
  } vn_div_t;

endpackage

@@ rtl/vector3_normalize_core.sv @@
// Top level of the 3D vector normalize core: length and unit vector of a Q8.8 vector.
//
//   channel   ports                       beat taken at
//   input     start_i, busy_o, vec_i      rising edge with start_i high and busy_o low
//   result    done_o, result_o            rising edge ending the cycle done_o is high
//
// One vector per cycle; each result passes through 3 front stages, 8 square root stages,
// 8 divider stages and 1 output register.
// busy_o stays low: the pipeline has no stall and the receiver cannot hold off.
// Reset clears all valid bits; beats in flight are dropped.
module vector3_normalize_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  vn_pkg::vn_in_t   vec_i,
  output logic             done_o,
  output vn_pkg::vn_out_t  result_o
);
  import vn_pkg::*;

  logic                  sq_valid, rt_valid, dv_valid;
  logic [SUM_WIDTH-1:0]  sq_sum;
  vn_meta_t              sq_meta, rt_meta;
  mag_t                  rt_root;
  vn_div_t               dv;
  logic                  done_q;
  vn_out_t               result_d, result_q;
  logic [LANES-1:0][UNIT_WIDTH-1:0] unit;

  assign busy_o = 1'b0;

  vn_square u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .vec_i   (vec_i),
    .valid_o (sq_valid),
    .sum_o   (sq_sum),
    .meta_o  (sq_meta)
  );

  vn_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .sum_i   (sq_sum),
    .meta_i  (sq_meta),
    .valid_o (rt_valid),
    .root_o  (rt_root),
    .meta_o  (rt_meta)
  );

  vn_divide u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rt_valid),
    .len_i   (rt_root),
    .meta_i  (rt_meta),
    .valid_o (dv_valid),
    .div_o   (dv)
  );

  always_comb begin
    logic [QUO_WIDTH-1:0]  sat;
    logic [UNIT_WIDTH-1:0] mag_u;
    sat   = '0;
    mag_u = '0;
    for (int i = 0; i < LANES; i++) begin
      sat     = (dv.quo[i] > UNIT_ONE) ? UNIT_ONE : dv.quo[i];
      mag_u   = UNIT_WIDTH'(sat);
      unit[i] = dv.zero ? '0 : (dv.neg[i] ? (~mag_u + UNIT_WIDTH'(1)) : mag_u);
    end
    result_d             = '0;
    result_d.length      = dv.len;
    result_d.unit_x      = unit[2];
    result_d.unit_y      = unit[1];
    result_d.unit_z      = unit[0];
    result_d.zero_vector = dv.zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LATENCY done_o)
    else $error("result missing after fixed latency");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LATENCY))
    else $error("result without matching start");

  a_zero_units : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.zero_vector) |->
      (result_o.length == '0 && result_o.unit_x == '0 &&
       result_o.unit_y == '0 && result_o.unit_z == '0))
    else $error("zero vector with nonzero outputs");

  a_unit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($signed(result_o.unit_x) <= $signed(UNIT_ONE_W) &&
                $signed(result_o.unit_x) >= -$signed(UNIT_ONE_W))
    )
    else $error("unit component out of range");

endmodule

@@ rtl/vn_square.sv @@
// Front stages: component magnitudes, squares and sum of squares.
module vn_square (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  vn_pkg::vn_in_t  vec_i,
  output logic            valid_o,
  output logic [vn_pkg::SUM_WIDTH-1:0] sum_o,
  output vn_pkg::vn_meta_t meta_o
);
  import vn_pkg::*;

  logic [2:0]                       v_q;
  vn_meta_t                         meta_a_d, meta_a_q, meta_b_q, meta_c_q;
  logic [LANES-1:0][SUM_WIDTH-1:0]  sq_d, sq_q;
  logic [SUM_WIDTH-1:0]             sum_d, sum_q;
  mag_t [LANES-1:0]                 raw;

  assign raw = {mag_t'(vec_i.vec_x), mag_t'(vec_i.vec_y), mag_t'(vec_i.vec_z)};

  always_comb begin
    meta_a_d = '0;
    for (int i = 0; i < LANES; i++) begin
      meta_a_d.neg[i] = raw[i][COMP_WIDTH-1];
      meta_a_d.mag[i] = raw[i][COMP_WIDTH-1] ? (~raw[i] + mag_t'(1)) : raw[i];
    end
    meta_a_d.zero = (raw == '0);
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sq_d[i] = SUM_WIDTH'(meta_a_q.mag[i]) * SUM_WIDTH'(meta_a_q.mag[i]);
    end
  end

  assign sum_d = sq_q[0] + sq_q[1] + sq_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    meta_a_q <= meta_a_d;
    meta_b_q <= meta_a_q;
    sq_q     <= sq_d;
    meta_c_q <= meta_b_q;
    sum_q    <= sum_d;
  end

  assign valid_o = v_q[2];
  assign sum_o   = sum_q;
  assign meta_o  = meta_c_q;

endmodule

@@ rtl/vn_isqrt.sv @@
// Pipelined integer square root, two root bits per stage.
module vn_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [vn_pkg::SUM_WIDTH-1:0] sum_i,
  input  vn_pkg::vn_meta_t             meta_i,
  output logic                         valid_o,
  output logic [vn_pkg::COMP_WIDTH-1:0] root_o,
  output vn_pkg::vn_meta_t             meta_o
);
  import vn_pkg::*;

  logic [SQRT_STAGES-1:0] v_q;
  logic [SUM_WIDTH-1:0]   n_q    [SQRT_STAGES];
  mag_t                   r_q    [SQRT_STAGES];
  logic [REM_WIDTH-1:0]   rem_q  [SQRT_STAGES];
  vn_meta_t               meta_q [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic                 v_in;
    logic [SUM_WIDTH-1:0] n_in, n_d;
    mag_t                 r_in, r_d;
    logic [REM_WIDTH-1:0] rem_in, rem_d;
    vn_meta_t             meta_in;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign n_in    = sum_i;
      assign r_in    = '0;
      assign rem_in  = '0;
      assign meta_in = meta_i;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign n_in    = n_q[s-1];
      assign r_in    = r_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign meta_in = meta_q[s-1];
    end

    always_comb begin
      logic [REM_WIDTH-1:0] trial;
      n_d   = n_in;
      r_d   = r_in;
      rem_d = rem_in;
      trial = '0;
      for (int j = 0; j < SQRT_PER_STAGE; j++) begin
        if (s * SQRT_PER_STAGE + j < SQRT_STEPS) begin
          rem_d = {rem_d[REM_WIDTH-3:0], n_d[SUM_WIDTH-1 -: 2]};
          n_d   = {n_d[SUM_WIDTH-3:0], 2'b00};
          trial = REM_WIDTH'({r_d, 2'b01});
          if (rem_d >= trial) begin
            rem_d = rem_d - trial;
            r_d   = {r_d[COMP_WIDTH-2:0], 1'b1};
          end else begin
            r_d   = {r_d[COMP_WIDTH-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      n_q[s]    <= n_d;
      r_q[s]    <= r_d;
      rem_q[s]  <= rem_d;
      meta_q[s] <= meta_in;
    end
  end

  assign valid_o = v_q[SQRT_STAGES-1];
  assign root_o  = r_q[SQRT_STAGES-1];
  assign meta_o  = meta_q[SQRT_STAGES-1];

endmodule

@@ rtl/vn_divide.sv @@
// Pipelined three-lane restoring divider: magnitude scaled by the unit over the length.
module vn_divide (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [vn_pkg::COMP_WIDTH-1:0] len_i,
  input  vn_pkg::vn_meta_t              meta_i,
  output logic                          valid_o,
  output vn_pkg::vn_div_t               div_o
);
  import vn_pkg::*;

  typedef logic [LANES-1:0][DREM_WIDTH-1:0] drem_t;
  typedef logic [LANES-1:0][QUO_WIDTH-1:0]  dbits_t;

  logic [DIV_STAGES-1:0] v_q;
  drem_t                 rem_q [DIV_STAGES];
  dbits_t                dvd_q [DIV_STAGES];
  vn_div_t               st_q  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic    v_in;
    drem_t   rem_in, rem_d;
    dbits_t  dvd_in, dvd_d;
    vn_div_t st_in, st_d;

    if (s == 0) begin : g_first
      assign v_in = valid_i;
      always_comb begin
        st_in      = '0;
        st_in.len  = len_i;
        st_in.neg  = meta_i.neg;
        st_in.zero = meta_i.zero;
        for (int i = 0; i < LANES; i++) begin
          rem_in[i] = DREM_WIDTH'(meta_i.mag[i] >> 1);
          dvd_in[i] = {meta_i.mag[i][0], {UNIT_FRAC_BITS{1'b0}}};
        end
      end
    end else begin : g_next
      assign v_in   = v_q[s-1];
      assign rem_in = rem_q[s-1];
      assign dvd_in = dvd_q[s-1];
      assign st_in  = st_q[s-1];
    end

    always_comb begin
      logic [DREM_WIDTH-1:0] dsr;
      rem_d = rem_in;
      dvd_d = dvd_in;
      st_d  = st_in;
      dsr   = DREM_WIDTH'(st_in.len);
      for (int i = 0; i < LANES; i++) begin
        for (int j = 0; j < DIV_PER_STAGE; j++) begin
          if (s * DIV_PER_STAGE + j < DIV_STEPS) begin
            rem_d[i] = {rem_d[i][DREM_WIDTH-2:0], dvd_d[i][QUO_WIDTH-1]};
            dvd_d[i] = {dvd_d[i][QUO_WIDTH-2:0], 1'b0};
            if (rem_d[i] >= dsr) begin
              rem_d[i]    = rem_d[i] - dsr;
              st_d.quo[i] = {st_d.quo[i][QUO_WIDTH-2:0], 1'b1};
            end else begin
              st_d.quo[i] = {st_d.quo[i][QUO_WIDTH-2:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d;
      dvd_q[s] <= dvd_d;
      st_q[s]  <= st_d;
    end
  end

  assign valid_o = v_q[DIV_STAGES-1];
  assign div_o   = st_q[DIV_STAGES-1];

endmodule

@@ sim/tb_vector3_normalize_core.sv @@
// Testbench for vector3_normalize_core: predicts length and unit vector of each beat and checks results.
module tb_vector3_normalize_core;
  timeunit 1ns;
  timeprecision 1ps;

  import vn_pkg::*;

  localparam int              DRAIN_CYCLES = LATENCY + 4;
  localparam longint unsigned UNIT_FULL    = 64'd1 << UNIT_FRAC_BITS;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    start_i;
  logic    busy_o;
  vn_in_t  vec_i;
  logic    done_o;
  vn_out_t result_o;

  vn_out_t pending_units[$];
  int      mismatch_cnt = 0;
  bit      calm         = 1'b0;

  vector3_normalize_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .vec_i    (vec_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint unsigned sqrt_floor(input longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic vn_out_t normalize_vec(input vn_in_t v);
    logic signed [COMP_WIDTH-1:0] comp [LANES];
    longint unsigned              mag  [LANES];
    logic        [UNIT_WIDTH-1:0] unit [LANES];
    longint unsigned              sum_sq;
    longint unsigned              len;
    longint unsigned              q;
    vn_out_t                      r;
    comp[0] = v.vec_x;
    comp[1] = v.vec_y;
    comp[2] = v.vec_z;
    sum_sq  = 0;
    for (int i = 0; i < LANES; i++) begin
      mag[i] = (comp[i] < 0) ? -longint'(comp[i]) : longint'(comp[i]);
      sum_sq += mag[i] * mag[i];
    end
    len = sqrt_floor(sum_sq);
    for (int i = 0; i < LANES; i++) begin
      q = (len == 0) ? 0 : (mag[i] << UNIT_FRAC_BITS) / len;
      if (q > UNIT_FULL) q = UNIT_FULL;
      unit[i] = q[UNIT_WIDTH-1:0];
      if (comp[i] < 0) unit[i] = -unit[i];
    end
    r.length      = len[COMP_WIDTH-1:0];
    r.unit_x      = unit[0];
    r.unit_y      = unit[1];
    r.unit_z      = unit[2];
    r.zero_vector = (sum_sq == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [COMP_WIDTH-1:0] want,
                             input logic [COMP_WIDTH-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // expected results are queued on the accepting edge, matched in order
  always @(posedge clk_i) begin
    vn_out_t want;
    if (rst_ni) begin
      if (start_i && !busy_o) pending_units.push_back(normalize_vec(vec_i));
      if (done_o) begin
        if (pending_units.size() == 0) begin
          $display("%0t: result beat with none expected, expected none, actual %h",
                   $time, result_o);
          mismatch_cnt++;
        end else begin
          want = pending_units.pop_front();
          check_field("length", want.length, result_o.length);
          check_field("unit_x", want.unit_x, result_o.unit_x);
          check_field("unit_y", want.unit_y, result_o.unit_y);
          check_field("unit_z", want.unit_z, result_o.unit_z);
          check_field("zero_vector", COMP_WIDTH'(want.zero_vector),
                      COMP_WIDTH'(result_o.zero_vector));
        end
      end
    end
  end

  function automatic vn_in_t mk_vec(input int x, input int y, input int z);
    vn_in_t v;
    v.vec_x = COMP_WIDTH'(x);
    v.vec_y = COMP_WIDTH'(y);
    v.vec_z = COMP_WIDTH'(z);
    return v;
  endfunction

  function automatic vn_in_t noise_vec();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return vn_in_t'(w[$bits(vn_in_t)-1:0]);
  endfunction

  // called at an edge; returns at the edge that accepted the beat, start_i still high
  task automatic send_vec(input vn_in_t v);
    int gap;
    if ($urandom_range(19) == 0) calm = !calm;
    gap = calm ? 0 : $urandom_range(5);
    if (gap > 0) begin
      start_i <= 1'b0;
      vec_i   <= noise_vec();
      repeat (gap - 1) begin
        @(posedge clk_i);
        vec_i <= noise_vec();
      end
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    vec_i   <= v;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic drain_pipe();
    start_i <= 1'b0;
    vec_i   <= noise_vec();
    @(posedge clk_i);
    while (pending_units.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_vec(mk_vec(0, 0, 0));
    send_vec(mk_vec(1, 0, 0));
    send_vec(mk_vec(-1, 0, 0));
    send_vec(mk_vec(0, 1, 0));
    send_vec(mk_vec(0, 0, -1));
    send_vec(mk_vec(32767, 0, 0));
    send_vec(mk_vec(-32768, 0, 0));
    send_vec(mk_vec(0, 32767, 0));
    send_vec(mk_vec(0, -32768, 0));
    send_vec(mk_vec(0, 0, 32767));
    send_vec(mk_vec(0, 0, -32768));
    send_vec(mk_vec(32767, 32767, 32767));
    send_vec(mk_vec(-32768, -32768, -32768));
    send_vec(mk_vec(-32768, 32767, -32768));
    send_vec(mk_vec(768, 1024, 0));
    send_vec(mk_vec(256, 256, 256));
    send_vec(mk_vec(1, 1, 1));
    send_vec(mk_vec(-1, 1, -1));
    send_vec(mk_vec(21845, -21846, 10922));
    send_vec(mk_vec(256, 0, 0));
    send_vec(mk_vec(1, 2, 2));
    send_vec(mk_vec(100, -3, 7));
  endtask

  task automatic test_random_wide(input int count);
    repeat (count) send_vec(noise_vec());
  endtask

  // short vectors: coarse lengths, heavy truncation in the divide
  task automatic test_random_short(input int count);
    repeat (count) begin
      send_vec(mk_vec(int'($urandom_range(600)) - 300, int'($urandom_range(600)) - 300,
                      int'($urandom_range(600)) - 300));
    end
  endtask

  // one dominant lane: quotients close to full scale
  task automatic test_random_axis(input int count);
    int comp [LANES];
    int axis;
    repeat (count) begin
      axis = $urandom_range(LANES - 1);
      for (int i = 0; i < LANES; i++) comp[i] = int'($urandom_range(16)) - 8;
      comp[axis] = $signed(COMP_WIDTH'($urandom));
      send_vec(mk_vec(comp[0], comp[1], comp[2]));
    end
  endtask

  // components spread over all magnitudes
  task automatic test_random_scaled(input int count);
    logic signed [COMP_WIDTH-1:0] comp [LANES];
    repeat (count) begin
      for (int i = 0; i < LANES; i++) begin
        comp[i] = COMP_WIDTH'($urandom);
        comp[i] = comp[i] >>> $urandom_range(COMP_WIDTH - 1);
      end
      send_vec(mk_vec(comp[0], comp[1], comp[2]));
    end
  endtask

  initial begin
    rst_ni  <= 1'b0;
    start_i <= 1'b0;
    vec_i   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    drain_pipe();
    test_random_wide(200);
    drain_pipe();
    test_random_short(130);
    drain_pipe();
    test_random_axis(100);
    drain_pipe();
    test_random_scaled(100);
    drain_pipe();
    if (mismatch_cnt == 0) begin
      $display("vector3_normalize_core verification clean");
    end else begin
      $display("vector3_normalize_core verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("vector3_normalize_core verification failed");
    $finish;
  end

endmodule
